// ===== rtl/chull_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chull_pkg
// Shared constants and types of the Graham scan convex hull block.
// ----------------------------------------------------------------------------
package chull_pkg;

	localparam int DEF_MAX_POINTS = 8;
	localparam int DEF_COORD_BITS = 16;
	localparam int FIELD_BITS     = 16;
	localparam int MIN_HULL_PTS   = 3;

	typedef struct packed {
		logic ccw;
		logic zero;
		logic near;
	} geo_res_t;

endpackage

// ===== rtl/chull_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chull_if
// Point and hull vertex channels, valid/ready.
// ----------------------------------------------------------------------------
interface chull_pt_if;
	logic                            valid;
	logic                            ready;
	logic signed [15:0]              x_coord;
	logic signed [15:0]              y_coord;
	logic                            last_point;

	modport source (output valid, x_coord, y_coord, last_point, input ready);
	modport sink (input valid, x_coord, y_coord, last_point, output ready);
endinterface

interface chull_hull_if;
	logic                            valid;
	logic                            ready;
	logic signed [15:0]              hull_x;
	logic signed [15:0]              hull_y;
	logic                            last_vertex;
	logic                            too_few;
	logic                            dropped;

	modport source (output valid, hull_x, hull_y, last_vertex, too_few, dropped, input ready);
	modport sink (input valid, hull_x, hull_y, last_vertex, too_few, dropped, output ready);
endinterface

// ===== rtl/chull_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chull_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chull_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (re) begin
			rd <= mem_q[ra];
		end
	end

endmodule

// ===== rtl/chull_geo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chull_geo
// Orientation of (a, b, c) by cross product with one shared multiplier,
// plus a nearness test of b against c as seen from a.
// ----------------------------------------------------------------------------
module chull_geo import chull_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	output logic                         done,
	output geo_res_t                     res
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0] d1_q, d2_q, d3_q, d4_q;
	logic signed [PW-1:0] p1_q, p2_q;
	logic signed [PW:0]   o;
	logic                 near_q;
	logic [1:0]           step_q;
	logic signed [DW-1:0] ebx, eby, ecx, ecy;
	logic [DW-1:0]        abx, aby, acx, acy;
	logic [DW:0]          mb, mc;
	logic signed [DW-1:0] ma, mm;

	always_comb begin
		ebx = DW'(bx) - DW'(ax);
		eby = DW'(by) - DW'(ay);
		ecx = DW'(cx) - DW'(ax);
		ecy = DW'(cy) - DW'(ay);
		abx = ebx[DW-1] ? DW'(-ebx) : DW'(ebx);
		aby = eby[DW-1] ? DW'(-eby) : DW'(eby);
		acx = ecx[DW-1] ? DW'(-ecx) : DW'(ecx);
		acy = ecy[DW-1] ? DW'(-ecy) : DW'(ecy);
		mb  = {1'b0, abx} + {1'b0, aby};
		mc  = {1'b0, acx} + {1'b0, acy};
		ma  = (step_q == 2'd1) ? d1_q : d3_q;
		mm  = (step_q == 2'd1) ? d2_q : d4_q;
		o   = (PW+1)'(p1_q) - (PW+1)'(p2_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
			done   <= 1'b0;
		end else begin
			done <= (step_q == 2'd3);
			unique case (step_q)
				2'd0: begin
					if (start) begin
						d1_q   <= DW'(cy) - DW'(by);
						d2_q   <= DW'(bx) - DW'(ax);
						d3_q   <= DW'(by) - DW'(ay);
						d4_q   <= DW'(cx) - DW'(bx);
						near_q <= mb < mc;
						step_q <= 2'd1;
					end
				end
				2'd1: begin
					p1_q   <= ma * mm;
					step_q <= 2'd2;
				end
				2'd2: begin
					p2_q   <= ma * mm;
					step_q <= 2'd3;
				end
				default: begin
					res.ccw  <= !o[PW] && (o != '0);
					res.zero <= (o == '0);
					res.near <= near_q;
					step_q   <= 2'd0;
				end
			endcase
		end
	end

endmodule

// ===== rtl/convex_hull_graham_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_hull_graham_scan
// Graham scan convex hull over a stored point set.
//
//   channel  dir  payload                                       done when
//   pt       in   x_coord, y_coord, last_point                  valid & ready
//   hull     out  hull_x, hull_y, last_vertex, too_few, dropped valid & ready
//
// Points load at one per cycle; the pivot is tracked while loading.
// After the last point: order setup, an insertion sort whose compares use the
// shared multiplier, stack setup, a scan with turn tests and pops of the
// stack, and output of the vertices, which hull can stall.
// pt is held off from the last point until the last vertex is registered.
// Reset clears control state only; the memories need no clearing.
// ----------------------------------------------------------------------------
module convex_hull_graham_scan import chull_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	chull_pt_if.sink      pt,
	chull_hull_if.source  hull
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int CB = COORD_BITS;

	typedef enum logic [4:0] {
		S_LOAD, S_FEW, S_INIT,
		S_SR0, S_SR1, S_SR2, S_SJ0, S_SJ1, S_SJ2, S_SJ3, S_SW,
		S_SI0, S_SI1, S_SI2,
		S_SL0, S_SL1, S_SL2, S_SL3, S_SL4, S_SP1, S_SP2, S_SPUSH,
		S_EM0, S_EM1, S_EM2
	} state_t;

	state_t state_q;

	logic [CW-1:0] cnt_q, n_q, i_q, j_q, k_q, depth_q;
	logic          ovf_q, drop_q;
	logic [IW-1:0] piv_q, cur_q, oth_q, top_q, sec_q;
	logic signed [CB-1:0] pvx_q, pvy_q, curx_q, cury_q, topx_q, topy_q, secx_q, secy_q;

	logic signed [CB-1:0] in_x, in_y, px, py, gax, gay, gbx, gby, gcx, gcy;
	logic [FIELD_BITS-1:0] ox, oy;
	logic [CW-1:0]   nxt_cnt, jm1, dm3;
	logic            acc, take, newpiv, out_free, emit, geo_start, geo_done, precede;
	geo_res_t        geo_res;

	logic            pt_we, pt_re, ord_we, ord_re, stk_we, stk_re;
	logic [IW-1:0]   pt_wa, pt_ra, ord_wa, ord_ra, ord_wd, ord_rd, stk_wa, stk_ra, stk_wd, stk_rd;
	logic [2*CB-1:0] pt_rd;

	assign acc      = pt.valid && pt.ready;
	assign pt.ready = (state_q == S_LOAD);
	assign take     = (cnt_q != CW'(MAX_POINTS));
	assign nxt_cnt  = take ? cnt_q + 1'b1 : cnt_q;
	assign newpiv   = (cnt_q == '0) || (in_y < pvy_q) || ((in_y == pvy_q) && (in_x > pvx_q));
	assign out_free = !hull.valid || hull.ready;
	assign emit     = out_free && ((state_q == S_FEW) || (state_q == S_EM2));
	assign jm1      = j_q - 1'b1;
	assign dm3      = depth_q - CW'(3);
	assign px       = pt_rd[CB-1:0];
	assign py       = pt_rd[2*CB-1:CB];
	assign precede  = geo_res.zero ? geo_res.near : geo_res.ccw;

	always_comb begin
		for (int b = 0; b < CB; b++) begin
			in_x[b] = (b < FIELD_BITS) ? pt.x_coord[b] : 1'b0;
			in_y[b] = (b < FIELD_BITS) ? pt.y_coord[b] : 1'b0;
		end
		for (int b = 0; b < FIELD_BITS; b++) begin
			ox[b] = (b < CB) ? px[b] : px[CB-1];
			oy[b] = (b < CB) ? py[b] : py[CB-1];
		end
	end

	always_comb begin
		pt_we  = (state_q == S_LOAD) && acc && take;
		pt_wa  = cnt_q[IW-1:0];
		pt_re  = 1'b0;
		pt_ra  = ord_rd;
		ord_we = 1'b0;
		ord_wa = j_q[IW-1:0];
		ord_wd = cur_q;
		ord_re = 1'b0;
		ord_ra = i_q[IW-1:0];
		stk_we = 1'b0;
		stk_wa = depth_q[IW-1:0];
		stk_wd = cur_q;
		stk_re = 1'b0;
		stk_ra = k_q[IW-1:0];
		geo_start = 1'b0;
		gax = secx_q;
		gay = secy_q;
		gbx = topx_q;
		gby = topy_q;
		gcx = curx_q;
		gcy = cury_q;
		unique case (state_q)
			S_INIT: begin
				ord_we = 1'b1;
				ord_wa = i_q[IW-1:0];
				if (i_q == '0) begin
					ord_wd = piv_q;
				end else if (i_q[IW-1:0] == piv_q) begin
					ord_wd = '0;
				end else begin
					ord_wd = i_q[IW-1:0];
				end
			end
			S_SR0: ord_re = 1'b1;
			S_SR1, S_SJ1, S_SI1, S_SL1: pt_re = 1'b1;
			S_SJ0: begin
				ord_re = (j_q > CW'(1));
				ord_ra = jm1[IW-1:0];
			end
			S_SJ2: begin
				geo_start = 1'b1;
				gax = pvx_q;
				gay = pvy_q;
				gbx = curx_q;
				gby = cury_q;
				gcx = px;
				gcy = py;
			end
			S_SJ3: begin
				ord_we = geo_done && precede;
				ord_wd = oth_q;
			end
			S_SW: ord_we = 1'b1;
			S_SI0: begin
				ord_re = 1'b1;
				ord_ra = k_q[IW-1:0];
			end
			S_SL0: ord_re = (i_q != n_q);
			S_SL3: geo_start = (depth_q >= CW'(2));
			S_SL4: begin
				stk_re = geo_done && !geo_res.ccw && (depth_q >= CW'(3));
				stk_ra = dm3[IW-1:0];
			end
			S_SP1, S_EM1: begin
				pt_re = 1'b1;
				pt_ra = stk_rd;
			end
			S_SPUSH: stk_we = (depth_q != CW'(MAX_POINTS));
			S_EM0: stk_re = 1'b1;
			default: ;
		endcase
		if (state_q == S_SI1) begin
			stk_we = 1'b1;
			stk_wa = k_q[IW-1:0];
			stk_wd = ord_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			hull.valid <= 1'b0;
		end else begin
			if (hull.ready && !emit) begin
				hull.valid <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (acc) begin
						if (take && newpiv) begin
							pvx_q <= in_x;
							pvy_q <= in_y;
							piv_q <= cnt_q[IW-1:0];
						end
						if (pt.last_point) begin
							n_q    <= nxt_cnt;
							drop_q <= ovf_q || !take;
							cnt_q  <= '0;
							ovf_q  <= 1'b0;
							i_q    <= '0;
							state_q <= (nxt_cnt < CW'(MIN_HULL_PTS)) ? S_FEW : S_INIT;
						end else begin
							cnt_q <= nxt_cnt;
							ovf_q <= ovf_q || !take;
						end
					end
				end
				S_FEW: begin
					if (out_free) begin
						hull.valid       <= 1'b1;
						hull.hull_x      <= '0;
						hull.hull_y      <= '0;
						hull.last_vertex <= 1'b1;
						hull.too_few     <= 1'b1;
						hull.dropped     <= drop_q;
						state_q          <= S_LOAD;
					end
				end
				S_INIT: begin
					if (i_q == n_q - 1'b1) begin
						i_q     <= CW'(2);
						state_q <= S_SR0;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_SR0: state_q <= S_SR1;
				S_SR1: begin
					cur_q   <= ord_rd;
					j_q     <= i_q;
					state_q <= S_SR2;
				end
				S_SR2: begin
					curx_q  <= px;
					cury_q  <= py;
					state_q <= S_SJ0;
				end
				S_SJ0: state_q <= (j_q > CW'(1)) ? S_SJ1 : S_SW;
				S_SJ1: begin
					oth_q   <= ord_rd;
					state_q <= S_SJ2;
				end
				S_SJ2: state_q <= S_SJ3;
				S_SJ3: begin
					if (geo_done) begin
						if (precede) begin
							j_q     <= jm1;
							state_q <= S_SJ0;
						end else begin
							state_q <= S_SW;
						end
					end
				end
				S_SW: begin
					if (i_q == n_q - 1'b1) begin
						k_q     <= '0;
						state_q <= S_SI0;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SR0;
					end
				end
				S_SI0: state_q <= S_SI1;
				S_SI1: begin
					cur_q   <= ord_rd;
					state_q <= S_SI2;
				end
				S_SI2: begin
					sec_q  <= top_q;
					secx_q <= topx_q;
					secy_q <= topy_q;
					top_q  <= cur_q;
					topx_q <= px;
					topy_q <= py;
					if (k_q == CW'(2)) begin
						depth_q <= CW'(3);
						i_q     <= CW'(3);
						state_q <= S_SL0;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_SI0;
					end
				end
				S_SL0: begin
					if (i_q == n_q) begin
						k_q     <= depth_q - 1'b1;
						state_q <= S_EM0;
					end else begin
						state_q <= S_SL1;
					end
				end
				S_SL1: begin
					cur_q   <= ord_rd;
					state_q <= S_SL2;
				end
				S_SL2: begin
					curx_q  <= px;
					cury_q  <= py;
					state_q <= S_SL3;
				end
				S_SL3: state_q <= (depth_q >= CW'(2)) ? S_SL4 : S_SPUSH;
				S_SL4: begin
					if (geo_done) begin
						if (geo_res.ccw) begin
							state_q <= S_SPUSH;
						end else begin
							depth_q <= depth_q - 1'b1;
							top_q   <= sec_q;
							topx_q  <= secx_q;
							topy_q  <= secy_q;
							state_q <= (depth_q >= CW'(3)) ? S_SP1 : S_SL3;
						end
					end
				end
				S_SP1: begin
					sec_q   <= stk_rd;
					state_q <= S_SP2;
				end
				S_SP2: begin
					secx_q  <= px;
					secy_q  <= py;
					state_q <= S_SL3;
				end
				S_SPUSH: begin
					if (depth_q != CW'(MAX_POINTS)) begin
						depth_q <= depth_q + 1'b1;
						sec_q   <= top_q;
						secx_q  <= topx_q;
						secy_q  <= topy_q;
						top_q   <= cur_q;
						topx_q  <= curx_q;
						topy_q  <= cury_q;
					end
					i_q     <= i_q + 1'b1;
					state_q <= S_SL0;
				end
				S_EM0: state_q <= S_EM1;
				S_EM1: state_q <= S_EM2;
				S_EM2: begin
					if (out_free) begin
						hull.valid       <= 1'b1;
						hull.hull_x      <= ox;
						hull.hull_y      <= oy;
						hull.last_vertex <= (k_q == '0);
						hull.too_few     <= 1'b0;
						hull.dropped     <= drop_q;
						k_q              <= k_q - 1'b1;
						state_q          <= (k_q == '0) ? S_LOAD : S_EM0;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	chull_ram #(.WIDTH(2 * CB), .DEPTH(MAX_POINTS)) u_pt_ram (
		.clk(clk), .we(pt_we), .wa(pt_wa), .wd({in_y, in_x}),
		.re(pt_re), .ra(pt_ra), .rd(pt_rd)
	);

	chull_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_ord_ram (
		.clk(clk), .we(ord_we), .wa(ord_wa), .wd(ord_wd),
		.re(ord_re), .ra(ord_ra), .rd(ord_rd)
	);

	chull_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_stk_ram (
		.clk(clk), .we(stk_we), .wa(stk_wa), .wd(stk_wd),
		.re(stk_re), .ra(stk_ra), .rd(stk_rd)
	);

	chull_geo #(.COORD_BITS(CB)) u_geo (
		.clk(clk), .arst_n(arst_n), .start(geo_start),
		.ax(gax), .ay(gay), .bx(gbx), .by(gby), .cx(gcx), .cy(gcy),
		.done(geo_done), .res(geo_res)
	);

endmodule

// ===== rtl/chull_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chull_chk
// Port-level checks of the convex hull block, bound to the top level.
// ----------------------------------------------------------------------------
module chull_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        pt_valid,
	input logic        pt_ready,
	input logic        pt_last,
	input logic        hull_valid,
	input logic        hull_ready,
	input logic [15:0] hull_x,
	input logic [15:0] hull_y,
	input logic        hull_last,
	input logic        hull_few
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hull_valid && !hull_ready |=> hull_valid && $stable(hull_x) && $stable(hull_y))
		else $error("hull transaction dropped while stalled");

	a_few: assert property (@(posedge clk) disable iff (!arst_n)
		hull_valid && hull_few |-> hull_last && hull_x == '0 && hull_y == '0)
		else $error("too_few result malformed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && pt_ready && pt_last |=> !pt_ready)
		else $error("point taken during hull computation");

endmodule

bind convex_hull_graham_scan chull_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.pt_valid(pt.valid), .pt_ready(pt.ready), .pt_last(pt.last_point),
	.hull_valid(hull.valid), .hull_ready(hull.ready),
	.hull_x(hull.hull_x), .hull_y(hull.hull_y),
	.hull_last(hull.last_vertex), .hull_few(hull.too_few)
);

// ===== sim/convex_hull_graham_scan_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_hull_graham_scan_tb
// Self-checking bench for the Graham scan convex hull block: point sets are
// driven on the point channel, a scoreboard predicts the hull vertices of each
// set and checks every vertex transaction in order, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module convex_hull_graham_scan_tb;
	import chull_pkg::*;

	localparam int NPTS = DEF_MAX_POINTS;

	typedef struct packed {
		logic signed [15:0] hx;
		logic signed [15:0] hy;
		logic               lastv;
		logic               few;
		logic               drop;
	} vertex_t;

	class hull_scoreboard;
		longint px [NPTS];
		longint py [NPTS];
		int     count;
		bit     overflow;
		vertex_t pending[$];
		int     errors;
		int     sets;
		int     vertices;

		function void clear();
			count    = 0;
			overflow = 0;
		endfunction

		function int turn(int a, int b, int c);
			longint o;
			o = (py[c] - py[b]) * (px[b] - px[a]) - (py[b] - py[a]) * (px[c] - px[b]);
			if (o == 0)
				return 0;
			return (o > 0) ? 1 : 2;
		endfunction

		function longint sqdist(int a, int b);
			longint dx, dy;
			dx = px[b] - px[a];
			dy = py[b] - py[a];
			return dx * dx + dy * dy;
		endfunction

		function bit precedes(int pv, int a, int b);
			int t;
			t = turn(pv, a, b);
			if (t == 0)
				return sqdist(pv, a) < sqdist(pv, b);
			return t == 1;
		endfunction

		function void note_point(logic signed [15:0] x, logic signed [15:0] y, logic lp);
			int ord [NPTS];
			int stk [NPTS];
			int depth, piv, cur, j;
			vertex_t v;
			if (count < NPTS) begin
				px[count] = x;
				py[count] = y;
				count++;
			end else begin
				overflow = 1;
			end
			if (!lp)
				return;
			sets++;
			if (count < MIN_HULL_PTS) begin
				v = '{hx: 0, hy: 0, lastv: 1, few: 1, drop: overflow};
				pending.push_back(v);
				clear();
				return;
			end
			piv = 0;
			for (int i = 1; i < count; i++)
				if (py[i] < py[piv] || (py[i] == py[piv] && px[i] > px[piv]))
					piv = i;
			for (int i = 0; i < count; i++)
				ord[i] = i;
			ord[0] = piv;
			ord[piv] = 0;
			for (int i = 2; i < count; i++) begin
				cur = ord[i];
				j = i;
				while (j > 1 && precedes(piv, cur, ord[j-1])) begin
					ord[j] = ord[j-1];
					j--;
				end
				ord[j] = cur;
			end
			stk[0] = ord[0];
			stk[1] = ord[1];
			stk[2] = ord[2];
			depth = 3;
			for (int i = 3; i < count; i++) begin
				while (depth >= 2 && turn(stk[depth-2], stk[depth-1], ord[i]) != 1)
					depth--;
				if (depth < NPTS) begin
					stk[depth] = ord[i];
					depth++;
				end
			end
			for (int k = 0; k < depth; k++) begin
				v.hx    = 16'(px[stk[depth-1-k]]);
				v.hy    = 16'(py[stk[depth-1-k]]);
				v.lastv = (k + 1 == depth);
				v.few   = 0;
				v.drop  = overflow;
				pending.push_back(v);
			end
			clear();
		endfunction

		function void check_vertex(vertex_t act);
			vertex_t exp_v;
			if (pending.size() == 0) begin
				$display("%0t: unexpected vertex, expected none, actual %h", $time, act);
				errors++;
				return;
			end
			exp_v = pending.pop_front();
			vertices++;
			if (act.hx !== exp_v.hx)
				$display("%0t: hull_x expected %0d actual %0d", $time, exp_v.hx, act.hx);
			if (act.hy !== exp_v.hy)
				$display("%0t: hull_y expected %0d actual %0d", $time, exp_v.hy, act.hy);
			if (act.lastv !== exp_v.lastv)
				$display("%0t: last_vertex expected %b actual %b", $time, exp_v.lastv, act.lastv);
			if (act.few !== exp_v.few)
				$display("%0t: too_few expected %b actual %b", $time, exp_v.few, act.few);
			if (act.drop !== exp_v.drop)
				$display("%0t: dropped expected %b actual %b", $time, exp_v.drop, act.drop);
			if (act !== exp_v)
				errors++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   src_idle;
	int   snk_idle;
	int   points_sent;

	chull_pt_if   pt ();
	chull_hull_if hull ();

	hull_scoreboard sb;

	convex_hull_graham_scan uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pt     (pt.sink),
		.hull   (hull.source)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && hull.valid && hull.ready)
			sb.check_vertex({hull.hull_x, hull.hull_y, hull.last_vertex, hull.too_few,
				hull.dropped});
		if (arst_n && pt.valid && pt.ready)
			sb.note_point(pt.x_coord, pt.y_coord, pt.last_point);
	end

	always @(negedge clk)
		hull.ready <= arst_n && ($urandom_range(99) >= snk_idle);

	task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic lp);
		while ($urandom_range(99) < src_idle) begin
			pt.valid <= 0;
			@(negedge clk);
		end
		pt.valid      <= 1;
		pt.x_coord    <= x;
		pt.y_coord    <= y;
		pt.last_point <= lp;
		@(posedge clk);
		while (!pt.ready)
			@(posedge clk);
		@(negedge clk);
		points_sent++;
	endtask

	task automatic send_random_set();
		int n, mode;
		logic signed [15:0] x, y;
		n = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(8, 1);
		mode = $urandom_range(3);
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: begin
					x = 16'($urandom);
					y = 16'($urandom);
				end
				1: begin
					x = 16'($signed(4'($urandom)));
					y = 16'($signed(4'($urandom)));
				end
				2: begin
					x = 16'($urandom_range(6));
					y = 16'(x * 2 - 3);
				end
				default: begin
					x = 16'(($urandom_range(1) ? 16'sh7fff : -16'sh8000) - $urandom_range(3));
					y = 16'(($urandom_range(1) ? 16'sh7fff : -16'sh8000) + $urandom_range(3));
				end
			endcase
			send_point(x, y, i == n - 1);
		end
	endtask

	task automatic drain();
		pt.valid <= 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (800) @(negedge clk);
	endtask

	initial begin
		sb = new();
		sb.clear();
		pt.valid      = 0;
		pt.x_coord    = 0;
		pt.y_coord    = 0;
		pt.last_point = 0;
		hull.ready    = 0;
		src_idle      = 0;
		snk_idle      = 0;
		points_sent   = 0;
		arst_n        = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_point(5, 5, 1);
		send_point(1, 1, 0);
		send_point(2, 2, 1);
		send_point(-16'sh8000, -16'sh8000, 0);
		send_point(16'sh7fff, -16'sh8000, 0);
		send_point(16'sh7fff, 16'sh7fff, 0);
		send_point(-16'sh8000, 16'sh7fff, 1);
		send_point(0, 0, 0);
		send_point(4, 0, 0);
		send_point(2, 0, 0);
		send_point(4, 4, 0);
		send_point(0, 4, 0);
		send_point(2, 2, 0);
		send_point(0, 4, 0);
		send_point(3, 3, 0);
		send_point(-1, -1, 0);
		send_point(9, 9, 1);
		send_point(1, 2, 0);
		send_point(1, 2, 0);
		send_point(1, 2, 1);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			src_idle = (phase == 0) ? 33 : (phase == 1) ? 60 : 0;
			snk_idle = (phase == 0) ? 60 : (phase == 1) ? 33 : 0;
			while (points_sent < 20 + 103 * (phase + 1)) begin
				send_random_set();
				if ($urandom_range(7) == 0)
					drain();
			end
			drain();
		end

		$display("Covered %0d point transactions in %0d sets, %0d hull vertices checked.",
			points_sent, sb.sets, sb.vertices);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
